/* rtl/sspp_pkg.sv */
`default_nettype none

package sspp_pkg;

  // Pattern length and the width of a step position.
  localparam int unsigned STEP_COUNT = 16;
  localparam int unsigned POS_W      = $clog2(STEP_COUNT);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(STEP_COUNT - 1);

  localparam logic [15:0] TPS_RESET = 16'd500;
  localparam logic [6:0]  NOTE_BASE = 7'd60;
  localparam logic [6:0]  OCTAVE    = 7'd12;
  localparam logic [3:0]  NOTE_MAX  = 4'd12;

  // Key codes carried with a tick.
  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_PLAY     = 4'd1;
  localparam logic [3:0] CMD_REC      = 4'd2;
  localparam logic [3:0] CMD_BACK     = 4'd3;
  localparam logic [3:0] CMD_NEXT     = 4'd4;
  localparam logic [3:0] CMD_OCT_DOWN = 4'd5;
  localparam logic [3:0] CMD_OCT_UP   = 4'd6;
  localparam logic [3:0] CMD_ACCENT   = 4'd7;
  localparam logic [3:0] CMD_SLIDE    = 4'd8;
  localparam logic [3:0] CMD_NOTE     = 4'd9;

  // Run modes.
  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_PLAY = 2'd1;
  localparam logic [1:0] MODE_REC  = 2'd2;

  // One pattern step as held in the store.
  typedef struct packed {
    logic [3:0] note;
    logic       gate;
    logic       oct_down;
    logic       oct_up;
    logic       accent;
    logic       slide;
  } step_t;

  localparam step_t STEP_RESET = '{note: 4'd0, gate: 1'b1, oct_down: 1'b0,
                                   oct_up: 1'b0, accent: 1'b0, slide: 1'b0};

endpackage

`default_nettype wire

/* rtl/sspp_if.sv */
`default_nettype none

// Tick channel: one key code and note key per transfer.
interface sspp_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] cmd;
  logic [3:0] note_key;

  modport source (output valid, output cmd, output note_key, input ready);
  modport sink (input valid, input cmd, input note_key, output ready);
endinterface

// Result channel: the player state after one tick.
interface sspp_out_if;
  logic       valid;
  logic       ready;
  logic       gate_out;
  logic [6:0] midi_note;
  logic       accent_out;
  logic       slide_out;
  logic       previous_slide;
  logic [3:0] step_index;
  logic [1:0] mode_out;

  modport source (output valid, output gate_out, output midi_note, output accent_out,
                  output slide_out, output previous_slide, output step_index,
                  output mode_out, input ready);
  modport sink (input valid, input gate_out, input midi_note, input accent_out,
                input slide_out, input previous_slide, input step_index,
                input mode_out, output ready);
endinterface

// Configuration write channel: ticks per step.
interface sspp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/step_sequencer_pattern_player.sv */
// Step sequencer pattern player.
// in_ch carries one tick per transfer, optionally with a key press (cmd) and a
// note key. Every tick produces exactly one result transfer on out_ch with the
// gate, MIDI note, accent/slide flags of the current step, the slide flag of
// the step before it, the step position and the run mode. cfg_ch writes
// ticks_per_step (always ready) and also reloads the tick countdown; it is
// meant to be written only while no tick is in flight.
// A tick is parked in a one-entry input buffer, then goes through a key step that
// applies the key (read-modify-write of the pattern memory) and a clock step that
// applies the clock and loads the output register. The buffer can take the next
// tick while one is being worked on, and a buffered tick is taken as the one
// before it finishes its clock step; each tick reads the memory in both steps.
// When the receiver stalls, the finished result is held in the output register
// and one further tick can still be accepted into the input buffer.
// Synchronous reset (rst_n low) returns to stop mode at step 0 with the gate
// closed and ticks_per_step at 500; the pattern reads as note 0, gate on, all
// flags clear, through per-entry valid bits, so no clearing pass is needed.

`default_nettype none

module step_sequencer_pattern_player (
  input  wire           clk,
  input  wire           rst_n,
  sspp_in_if.sink       in_ch,
  sspp_out_if.source    out_ch,
  sspp_cfg_if.sink      cfg_ch
);

  localparam int unsigned PW = sspp_pkg::POS_W;

  // One-hot sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_KEY  = 3'b010,
    ST_CLK  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Pattern memory and its per-entry valid bits. An entry that was never
  // written reads as the reset step.
  sspp_pkg::step_t mem [sspp_pkg::STEP_COUNT];
  logic [sspp_pkg::STEP_COUNT-1:0] vld_r;

  // Input buffer and the tick being worked on.
  logic       buf_v_r;
  logic [3:0] buf_cmd_r, buf_key_r;
  logic [3:0] cur_cmd_r, cur_key_r;

  // Player state.
  logic [1:0]    mode_r;
  logic [PW-1:0] pos_r;
  logic [15:0]   cd_r;
  logic [15:0]   tps_r;
  logic          gate_r;
  logic          adv_r, start_r;

  // Memory read ports and write forwarding.
  logic [PW-1:0]   ra_a, ra_b, ra_a_r, ra_b_r;
  sspp_pkg::step_t rd_a_r, rd_b_r;
  logic            rd_a_v_r, rd_b_v_r;
  logic            fwd_v_r;
  logic [PW-1:0]   fwd_addr_r;
  sspp_pkg::step_t fwd_data_r;
  sspp_pkg::step_t ent_a, ent_b;

  // Output register.
  logic out_valid_r;

  // Key stage results.
  logic [1:0]      mode_k;
  logic [PW-1:0]   pos_k, pos_f, prev_f, prev_r;
  logic [15:0]     cd_k, cd_f;
  logic            start_k, adv_k, edit_k, mem_we;
  sspp_pkg::step_t ent_w;

  // Clock stage results.
  sspp_pkg::step_t ent_k;
  logic [15:0]     close_at;
  logic            gate_c, fin, take;
  logic [6:0]      midi_c;

  assign in_ch.ready  = ~buf_v_r;
  assign cfg_ch.ready = 1'b1;

  assign fin  = (state_r == ST_CLK) && (~out_valid_r || out_ch.ready);
  assign take = buf_v_r && ((state_r == ST_IDLE) || fin);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (take) state_nxt = ST_KEY;
      ST_KEY:  state_nxt = ST_CLK;
      ST_CLK: begin
        if (fin) state_nxt = take ? ST_KEY : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Read data with the reset value for unwritten entries and forwarding of the
  // write made in the previous cycle.
  always_comb begin
    ent_a = rd_a_v_r ? rd_a_r : sspp_pkg::STEP_RESET;
    if (fwd_v_r && (fwd_addr_r == ra_a_r)) ent_a = fwd_data_r;
    ent_b = rd_b_v_r ? rd_b_r : sspp_pkg::STEP_RESET;
    if (fwd_v_r && (fwd_addr_r == ra_b_r)) ent_b = fwd_data_r;
  end

  // Key handling. Port A holds the entry at the current step here.
  always_comb begin
    mode_k  = mode_r;
    pos_k   = pos_r;
    cd_k    = cd_r;
    start_k = 1'b0;
    edit_k  = 1'b0;
    ent_w   = ent_a;
    case (cur_cmd_r)
      sspp_pkg::CMD_PLAY: begin
        if (mode_r == sspp_pkg::MODE_PLAY) begin
          mode_k = sspp_pkg::MODE_STOP;
        end else begin
          pos_k   = '0;
          cd_k    = tps_r;
          start_k = 1'b1;
          mode_k  = sspp_pkg::MODE_PLAY;
        end
      end
      sspp_pkg::CMD_REC: begin
        mode_k = sspp_pkg::MODE_REC;
        pos_k  = '0;
      end
      sspp_pkg::CMD_BACK: begin
        if (mode_r == sspp_pkg::MODE_REC && pos_r != '0) pos_k = pos_r - 1'b1;
      end
      sspp_pkg::CMD_NEXT: begin
        if (mode_r == sspp_pkg::MODE_REC && pos_r != sspp_pkg::POS_LAST) begin
          pos_k = pos_r + 1'b1;
        end
      end
      sspp_pkg::CMD_OCT_DOWN: begin
        edit_k = (mode_r == sspp_pkg::MODE_REC);
        ent_w.oct_down = ~ent_a.oct_down;
      end
      sspp_pkg::CMD_OCT_UP: begin
        edit_k = (mode_r == sspp_pkg::MODE_REC);
        ent_w.oct_up = ~ent_a.oct_up;
      end
      sspp_pkg::CMD_ACCENT: begin
        edit_k = (mode_r == sspp_pkg::MODE_REC);
        ent_w.accent = ~ent_a.accent;
      end
      sspp_pkg::CMD_SLIDE: begin
        edit_k = (mode_r == sspp_pkg::MODE_REC);
        ent_w.slide = ~ent_a.slide;
      end
      sspp_pkg::CMD_NOTE: begin
        edit_k = (mode_r == sspp_pkg::MODE_REC) && (cur_key_r <= sspp_pkg::NOTE_MAX);
        if (ent_a.note == cur_key_r) begin
          ent_w.gate = ~ent_a.gate;
        end else begin
          ent_w.gate = 1'b1;
          ent_w.note = cur_key_r;
        end
      end
      default: ;
    endcase
    // The clock's step advance is decided here too, so that the clock stage
    // finds both the new step and its predecessor on the two read ports.
    adv_k  = (mode_k == sspp_pkg::MODE_PLAY) && (cd_k == '0);
    if (adv_k) begin
      pos_f = (pos_k == sspp_pkg::POS_LAST) ? '0 : pos_k + 1'b1;
    end else begin
      pos_f = pos_k;
    end
    cd_f   = adv_k ? tps_r : cd_k;
    prev_f = (pos_f == '0) ? sspp_pkg::POS_LAST : pos_f - 1'b1;
  end

  assign mem_we = (state_r == ST_KEY) && edit_k;
  assign prev_r = (pos_r == '0) ? sspp_pkg::POS_LAST : pos_r - 1'b1;
  assign ra_a   = (state_r == ST_KEY) ? pos_f  : pos_r;
  assign ra_b   = (state_r == ST_KEY) ? prev_f : prev_r;

  // Clock handling. Port A holds the final step, port B the step before it;
  // when the step advanced, the step that the key left is the one on port B.
  always_comb begin
    ent_k    = adv_r ? ent_b : ent_a;
    close_at = tps_r - {1'b0, tps_r[15:1]};
    gate_c   = gate_r;
    if (start_r && ent_k.gate) gate_c = 1'b1;
    if (adv_r && ent_a.gate) gate_c = 1'b1;
    if ((cd_r <= close_at) && gate_c &&
        !(ent_a.slide && mode_r == sspp_pkg::MODE_PLAY)) begin
      gate_c = 1'b0;
    end
    midi_c = sspp_pkg::NOTE_BASE + {3'b000, ent_a.note};
    if (ent_a.oct_down) midi_c = midi_c - sspp_pkg::OCTAVE;
    if (ent_a.oct_up) midi_c = midi_c + sspp_pkg::OCTAVE;
  end

  // Pattern memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) mem[pos_r] <= ent_w;
    rd_a_r     <= mem[ra_a];
    rd_b_r     <= mem[ra_b];
    ra_a_r     <= ra_a;
    ra_b_r     <= ra_b;
    fwd_addr_r <= pos_r;
    fwd_data_r <= ent_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_a_v_r <= 1'b0;
      rd_b_v_r <= 1'b0;
      fwd_v_r  <= 1'b0;
    end else begin
      if (mem_we) vld_r[pos_r] <= 1'b1;
      rd_a_v_r <= vld_r[ra_a];
      rd_b_v_r <= vld_r[ra_b];
      fwd_v_r  <= mem_we;
    end
  end

  // Input buffer and current tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
    end else if (take) begin
      buf_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      buf_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      buf_cmd_r <= in_ch.cmd;
      buf_key_r <= in_ch.note_key;
    end
    if (take) begin
      cur_cmd_r <= buf_cmd_r;
      cur_key_r <= buf_key_r;
    end
  end

  // Control state and player state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= sspp_pkg::MODE_STOP;
      pos_r   <= '0;
      cd_r    <= sspp_pkg::TPS_RESET;
      tps_r   <= sspp_pkg::TPS_RESET;
      gate_r  <= 1'b0;
      adv_r   <= 1'b0;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        tps_r <= cfg_ch.data;
        cd_r  <= cfg_ch.data;
      end else if (state_r == ST_KEY) begin
        cd_r <= cd_f;
      end else if (fin && cd_r != '0) begin
        cd_r <= cd_r - 1'b1;
      end
      if (state_r == ST_KEY) begin
        mode_r  <= mode_k;
        pos_r   <= pos_f;
        adv_r   <= adv_k;
        start_r <= start_k;
      end
      if (fin) gate_r <= gate_c;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_ch.gate_out       <= gate_c;
      out_ch.midi_note      <= midi_c;
      out_ch.accent_out     <= ent_a.accent;
      out_ch.slide_out      <= ent_a.slide;
      out_ch.previous_slide <= ent_b.slide;
      out_ch.step_index     <= 4'(pos_r);
      out_ch.mode_out       <= mode_r;
    end
  end

  assign out_ch.valid = out_valid_r;

  // The pattern is only edited in record mode, during the key cycle.
  a_we_rec: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_KEY) && (mode_r == sspp_pkg::MODE_REC))
    else $error("pattern write outside record key cycle");

  // The key cycle is always followed by the clock cycle.
  a_key_clk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KEY) |=> (state_r == ST_CLK))
    else $error("key cycle not followed by clock cycle");

  // A new result appears only as a tick finishes its clock cycle.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fin))
    else $error("result raised without a finished tick");

  // An edit never moves the step, so the written entry is the final step.
  a_edit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (pos_f == pos_r))
    else $error("edit coincides with a step move");

  // The run mode stays within its three codes.
  a_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == sspp_pkg::MODE_STOP) || (mode_r == sspp_pkg::MODE_PLAY) ||
    (mode_r == sspp_pkg::MODE_REC))
    else $error("illegal run mode");

endmodule

`default_nettype wire

/* test/step_sequencer_pattern_player_tb.sv */
`default_nettype none

module step_sequencer_pattern_player_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Key codes that the block has no use for. They must pass through as plain ticks.
  localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  // This many quiet cycles after the last result cover anything still in flight.
  localparam int SETTLE_CYCLES = 8;
  // The longest correct stretch without any transfer is a long input gap, then the
  // pipeline, then a long output stall. This limit allows many times that.
  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    logic [3:0] cmd;
    logic [3:0] key;
  } tick_t;

  // The player state that one tick leaves behind, as seen on the result channel.
  typedef struct packed {
    logic       gate;
    logic [6:0] midi;
    logic       accent;
    logic       slide;
    logic       prev_slide;
    logic [3:0] step;
    logic [1:0] mode;
  } player_view_t;

  logic clk;
  logic rst_n;

  sspp_in_if  in_ch ();
  sspp_out_if out_ch ();
  sspp_cfg_if cfg_ch ();

  step_sequencer_pattern_player dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Our own copy of the sequencer: pattern, mode, position, countdown and gate.
  sspp_pkg::step_t            song_steps [sspp_pkg::STEP_COUNT];
  logic [1:0]                 play_mode;
  logic [sspp_pkg::POS_W-1:0] cur_step;
  logic [15:0]                tick_count;
  logic                       gate_on;
  logic [15:0]                step_ticks;

  tick_t        pending_ticks [$];
  player_view_t predicted_views [$];
  tick_t        next_tick;

  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned quiet_cycles;
  int unsigned failures;
  // Ticks put on the channel and results taken off it, for the drain check.
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  // When set, neither side idles. The driver flips it now and then so that runs
  // at full rate alternate with runs full of gaps and stalls.
  logic        steady_flow;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_failure(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      note_failure($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Most pauses are short; a few are long enough to drain the block completely.
  function automatic int unsigned random_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Entering a step reloads the countdown and opens the gate if the step has one.
  function automatic void open_step();
    tick_count = step_ticks;
    if (song_steps[cur_step].gate) begin
      gate_on = 1'b1;
    end
  endfunction

  // One tick: the key is applied first, then the clock, then the view is taken.
  function automatic player_view_t advance_player(input logic [3:0] cmd,
                                                  input logic [3:0] key);
    logic                       in_rec;
    logic [sspp_pkg::POS_W-1:0] here;
    logic [sspp_pkg::POS_W-1:0] before_pos;
    logic [15:0]                close_at;
    player_view_t               v;
    in_rec = (play_mode == sspp_pkg::MODE_REC);
    here   = cur_step;
    case (cmd)
      sspp_pkg::CMD_PLAY: begin
        if (play_mode == sspp_pkg::MODE_PLAY) begin
          play_mode = sspp_pkg::MODE_STOP;
        end else begin
          cur_step = '0;
          open_step();
          play_mode = sspp_pkg::MODE_PLAY;
        end
      end
      sspp_pkg::CMD_REC: begin
        play_mode = sspp_pkg::MODE_REC;
        cur_step  = '0;
      end
      sspp_pkg::CMD_BACK: begin
        if (in_rec && cur_step != '0) cur_step = cur_step - 1'b1;
      end
      sspp_pkg::CMD_NEXT: begin
        if (in_rec && cur_step != sspp_pkg::POS_LAST) cur_step = cur_step + 1'b1;
      end
      sspp_pkg::CMD_OCT_DOWN: begin
        if (in_rec) song_steps[here].oct_down = !song_steps[here].oct_down;
      end
      sspp_pkg::CMD_OCT_UP: begin
        if (in_rec) song_steps[here].oct_up = !song_steps[here].oct_up;
      end
      sspp_pkg::CMD_ACCENT: begin
        if (in_rec) song_steps[here].accent = !song_steps[here].accent;
      end
      sspp_pkg::CMD_SLIDE: begin
        if (in_rec) song_steps[here].slide = !song_steps[here].slide;
      end
      sspp_pkg::CMD_NOTE: begin
        // Pressing the note already stored toggles the gate; a new note sets it.
        if (in_rec && key <= sspp_pkg::NOTE_MAX) begin
          if (song_steps[here].note == key) begin
            song_steps[here].gate = !song_steps[here].gate;
          end else begin
            song_steps[here].gate = 1'b1;
            song_steps[here].note = key;
          end
        end
      end
      default: begin
      end
    endcase

    if (play_mode == sspp_pkg::MODE_PLAY && tick_count == 16'd0) begin
      cur_step = sspp_pkg::POS_W'((cur_step + 1) % sspp_pkg::STEP_COUNT);
      open_step();
    end
    // The gate closes half a step in, except on a sliding step during play.
    close_at = step_ticks - (step_ticks >> 1);
    if (tick_count <= close_at && gate_on &&
        !(song_steps[cur_step].slide && play_mode == sspp_pkg::MODE_PLAY)) begin
      gate_on = 1'b0;
    end
    if (tick_count != 16'd0) tick_count = tick_count - 1'b1;

    before_pos   = sspp_pkg::POS_W'((cur_step + sspp_pkg::STEP_COUNT - 1) %
                                    sspp_pkg::STEP_COUNT);
    v.gate       = gate_on;
    v.midi       = sspp_pkg::NOTE_BASE + 7'(song_steps[cur_step].note);
    if (song_steps[cur_step].oct_down) v.midi = v.midi - sspp_pkg::OCTAVE;
    if (song_steps[cur_step].oct_up) v.midi = v.midi + sspp_pkg::OCTAVE;
    v.accent     = song_steps[cur_step].accent;
    v.slide      = song_steps[cur_step].slide;
    v.prev_slide = song_steps[before_pos].slide;
    v.step       = 4'(cur_step);
    v.mode       = play_mode;
    return v;
  endfunction

  function automatic void push_tick(input logic [3:0] cmd, input logic [3:0] key);
    tick_t t;
    t.cmd = cmd;
    t.key = key;
    pending_ticks.push_back(t);
  endfunction

  // Mostly a valid semitone, sometimes one of the keys above the octave.
  function automatic logic [3:0] edit_key();
    if ($urandom_range(0, 9) == 0) begin
      return 4'($urandom_range(sspp_pkg::NOTE_MAX + 1, 15));
    end
    return 4'($urandom_range(0, sspp_pkg::NOTE_MAX));
  endfunction

  // Record a whole pattern: step through every position with up to three edits at
  // each, and walk past the last one, which must leave the position stuck at the end.
  function automatic void program_pattern();
    int unsigned edits;
    push_tick(sspp_pkg::CMD_REC, 4'($urandom));
    for (int s = 0; s < sspp_pkg::STEP_COUNT; s++) begin
      edits = $urandom_range(0, 3);
      for (int e = 0; e < edits; e++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_tick(sspp_pkg::CMD_BACK, 4'($urandom));
        end else begin
          push_tick(4'($urandom_range(sspp_pkg::CMD_OCT_DOWN, sspp_pkg::CMD_NOTE)),
                    edit_key());
        end
      end
      push_tick(sspp_pkg::CMD_NEXT, 4'($urandom));
    end
    push_tick(sspp_pkg::CMD_NEXT, 4'($urandom));
  endfunction

  // Start playback, let it run with the odd stray key, and maybe stop it again.
  function automatic void play_run();
    int unsigned len;
    push_tick(sspp_pkg::CMD_PLAY, 4'($urandom));
    len = $urandom_range(8, 40);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_tick(4'($urandom), 4'($urandom));
      end else begin
        push_tick(sspp_pkg::CMD_NONE, 4'($urandom));
      end
    end
    if ($urandom_range(0, 1) == 0) begin
      push_tick(sspp_pkg::CMD_PLAY, 4'($urandom));
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) push_tick(sspp_pkg::CMD_NONE, 4'($urandom));
    end
  endfunction

  // A short record session that wanders back and forth over the first steps.
  function automatic void record_walk();
    int unsigned len;
    push_tick(sspp_pkg::CMD_REC, 4'($urandom));
    len = $urandom_range(5, 15);
    for (int i = 0; i < len; i++) begin
      push_tick(4'($urandom_range(sspp_pkg::CMD_BACK, sspp_pkg::CMD_NOTE)), edit_key());
    end
  endfunction

  function automatic void add_random_ticks(input int unsigned budget);
    int unsigned target;
    int unsigned len;
    target = pending_ticks.size() + budget;
    while (pending_ticks.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: program_pattern();
        3, 4, 5, 6: play_run();
        7: record_walk();
        default: begin
          len = $urandom_range(3, 12);
          for (int i = 0; i < len; i++) push_tick(4'($urandom), 4'($urandom));
        end
      endcase
    end
  endfunction

  // The register write also reloads the countdown, so the copy does the same.
  task automatic set_ticks_per_step(input logic [15:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    step_ticks = value;
    tick_count = value;
  endtask

  // Wait until every tick has been sent and every result has come back, then
  // give the block a few more cycles before anything else touches it.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_ticks.size() != 0 || ticks_sent != results_seen);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Tick driver. The expected view is computed at the very edge at which a tick
  // transfers, so the copy of the state always follows the block's order.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_views.push_back(advance_player(in_ch.cmd, in_ch.note_key));
      end
      if (in_ch.valid && !in_ch.ready) begin
        // The tick stays on the channel until the block takes it.
      end else if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap--;
      end else if (pending_ticks.size() > 0) begin
        next_tick = pending_ticks.pop_front();
        ticks_sent++;
        in_ch.valid    <= 1'b1;
        in_ch.cmd      <= next_tick.cmd;
        in_ch.note_key <= next_tick.key;
        if ($urandom_range(0, 63) == 0) steady_flow = !steady_flow;
        in_gap = steady_flow ? 0 : random_pause();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor. Each result transfer is matched against the oldest
  // expected view, field by field. Stalls start after transfers and at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (predicted_views.size() == 0) begin
          note_failure("result transfer with no tick outstanding");
        end else begin
          player_view_t want;
          want = predicted_views.pop_front();
          check_field("gate_out", out_ch.gate_out, want.gate);
          check_field("midi_note", out_ch.midi_note, want.midi);
          check_field("accent_out", out_ch.accent_out, want.accent);
          check_field("slide_out", out_ch.slide_out, want.slide);
          check_field("previous_slide", out_ch.previous_slide, want.prev_slide);
          check_field("step_index", out_ch.step_index, want.step);
          check_field("mode_out", out_ch.mode_out, want.mode);
        end
        out_stall = steady_flow ? 0 : random_pause();
      end else if (out_stall == 0 && !steady_flow && $urandom_range(0, 15) == 0) begin
        out_stall = random_pause();
      end
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transfer on any channel means the block hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] phase_ticks [$];
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= '0;
    rst_n          <= 1'b0;
    steady_flow    = 1'b0;
    failures       = 0;
    quiet_cycles   = 0;

    // State after reset: a blank pattern with every gate on, stopped at step 0.
    foreach (song_steps[i]) song_steps[i] = sspp_pkg::STEP_RESET;
    play_mode  = sspp_pkg::MODE_STOP;
    cur_step   = '0;
    step_ticks = sspp_pkg::TPS_RESET;
    tick_count = sspp_pkg::TPS_RESET;
    gate_on    = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with a short step so that playback moves within a few ticks.
    set_ticks_per_step(16'd4);
    push_tick(sspp_pkg::CMD_NONE, 4'd0);
    // Editing keys while stopped must change nothing.
    push_tick(sspp_pkg::CMD_NEXT, 4'd15);
    push_tick(sspp_pkg::CMD_ACCENT, 4'd0);
    push_tick(sspp_pkg::CMD_NOTE, 4'd7);
    // Codes beyond the note key are plain ticks.
    push_tick(CMD_UNUSED_LO, 4'd0);
    push_tick(CMD_UNUSED_HI, 4'd15);
    push_tick(sspp_pkg::CMD_REC, 4'd0);
    // Back at the first step stays there.
    push_tick(sspp_pkg::CMD_BACK, 4'd0);
    // Pressing the stored note twice turns the gate off and on again.
    push_tick(sspp_pkg::CMD_NOTE, 4'd0);
    push_tick(sspp_pkg::CMD_NOTE, 4'd0);
    push_tick(sspp_pkg::CMD_NOTE, sspp_pkg::NOTE_MAX);
    // Keys above the octave are ignored.
    push_tick(sspp_pkg::CMD_NOTE, sspp_pkg::NOTE_MAX + 4'd1);
    push_tick(sspp_pkg::CMD_NOTE, 4'd15);
    // Both octave flags cancel; dropping octave down again leaves the top note an octave up.
    push_tick(sspp_pkg::CMD_OCT_DOWN, 4'd0);
    push_tick(sspp_pkg::CMD_OCT_UP, 4'd0);
    push_tick(sspp_pkg::CMD_OCT_DOWN, 4'd0);
    push_tick(sspp_pkg::CMD_ACCENT, 4'd0);
    push_tick(sspp_pkg::CMD_SLIDE, 4'd0);
    push_tick(sspp_pkg::CMD_NEXT, 4'd0);
    push_tick(sspp_pkg::CMD_PLAY, 4'd0);
    repeat (4) push_tick(sspp_pkg::CMD_NONE, 4'd0);
    // Play while playing stops.
    push_tick(sspp_pkg::CMD_PLAY, 4'd0);
    push_tick(sspp_pkg::CMD_NONE, 4'd0);
    wait_drained();

    // Random phases, each under its own step length: the shortest, zero, the
    // longest and a few in between. Long steps get fewer ticks, since playback
    // cannot advance within them anyway.
    phase_ticks = '{16'd1, 16'd3, 16'd0, 16'd2, 16'd65535, 16'd6, 16'd1, 16'd5, 16'd2};
    foreach (phase_ticks[i]) begin
      set_ticks_per_step(phase_ticks[i]);
      add_random_ticks(phase_ticks[i] > 16'd100 ? 25 : 55);
      wait_drained();
    end

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* step_sequencer_pattern_player.f */
rtl/sspp_pkg.sv
rtl/sspp_if.sv
rtl/step_sequencer_pattern_player.sv
test/step_sequencer_pattern_player_tb.sv
